// ----- hdl/alu8f_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alu8f_pkg
// Operation codes and flag type shared by the eight-bit ALU and its checker.
// ----------------------------------------------------------------------------
package alu8f_pkg;

    localparam int unsigned OpWidth = 5;

    typedef enum logic [OpWidth-1:0] {
        OP_ADD  = 5'd0,
        OP_ADC  = 5'd1,
        OP_SUB  = 5'd2,
        OP_SBC  = 5'd3,
        OP_AND  = 5'd4,
        OP_XOR  = 5'd5,
        OP_OR   = 5'd6,
        OP_CP   = 5'd7,
        OP_INC  = 5'd8,
        OP_DEC  = 5'd9,
        OP_DAA  = 5'd10,
        OP_CPL  = 5'd11,
        OP_SCF  = 5'd12,
        OP_CCF  = 5'd13,
        OP_RLC  = 5'd14,
        OP_RRC  = 5'd15,
        OP_RL   = 5'd16,
        OP_RR   = 5'd17,
        OP_SLA  = 5'd18,
        OP_SRA  = 5'd19,
        OP_SRL  = 5'd20,
        OP_SWAP = 5'd21,
        OP_BIT  = 5'd22,
        OP_RES  = 5'd23,
        OP_SET  = 5'd24,
        OP_RLCA = 5'd25,
        OP_RRCA = 5'd26,
        OP_RLA  = 5'd27,
        OP_RRA  = 5'd28
    } t_alu_op;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } t_flags;

    localparam logic [7:0] DaaHighAdj  = 8'h60;
    localparam logic [7:0] DaaLowAdj   = 8'h06;
    localparam logic [7:0] DaaHighLim  = 8'h99;
    localparam logic [3:0] DaaLowLim   = 4'h9;

endpackage : alu8f_pkg
`default_nettype wire

// ----- hdl/alu8f_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alu8f_core
// Combinational datapath: result, write-back enable and new flags of one item.
// ----------------------------------------------------------------------------
module alu8f_core
    import alu8f_pkg::*;
(
    input  wire logic [OpWidth-1:0] i_operation,
    input  wire logic [7:0]         i_a,
    input  wire logic [7:0]         i_b,
    input  wire logic [2:0]         i_bit_index,
    input  wire t_flags             i_flags,
    output logic      [7:0]         o_result,
    output logic                    o_written,
    output t_flags                  o_flags
);

    logic       cin;
    logic [8:0] sum9;
    logic [4:0] sum5;
    logic [8:0] dif9;
    logic [4:0] dif5;
    logic [7:0] bit_mask;
    logic       daa_hi;
    logic [7:0] daa_mid;
    logic [7:0] daa_res;
    logic [7:0] r;
    logic       set_z;
    t_flags     f;

    // Carry in only for the with-carry forms.
    assign cin = ((t_alu_op'(i_operation) == OP_ADC) || (t_alu_op'(i_operation) == OP_SBC))
                 ? i_flags.c : 1'b0;

    assign sum9 = {1'b0, i_a} + {1'b0, i_b} + {8'd0, cin};
    assign sum5 = {1'b0, i_a[3:0]} + {1'b0, i_b[3:0]} + {4'd0, cin};
    // The top bit of each difference is the borrow out of that width.
    assign dif9 = {1'b0, i_a} - {1'b0, i_b} - {8'd0, cin};
    assign dif5 = {1'b0, i_a[3:0]} - {1'b0, i_b[3:0]} - {4'd0, cin};

    assign bit_mask = 8'd1 << i_bit_index;

    // Decimal adjust: the high correction never changes the low nibble.
    assign daa_hi  = i_flags.c || (i_a > DaaHighLim);
    always_comb begin
        if (!i_flags.n) begin
            daa_mid = daa_hi ? (i_a + DaaHighAdj) : i_a;
            daa_res = (i_flags.h || (daa_mid[3:0] > DaaLowLim)) ? (daa_mid + DaaLowAdj)
                                                                 : daa_mid;
        end else begin
            daa_mid = i_flags.c ? (i_a - DaaHighAdj) : i_a;
            daa_res = i_flags.h ? (daa_mid - DaaLowAdj) : daa_mid;
        end
    end

    always_comb begin
        r         = i_a;
        f         = i_flags;
        set_z     = 1'b1;
        o_written = 1'b1;
        case (t_alu_op'(i_operation))
            OP_ADD, OP_ADC: begin
                r   = sum9[7:0];
                f.n = 1'b0;
                f.h = sum5[4];
                f.c = sum9[8];
            end
            OP_SUB, OP_SBC, OP_CP: begin
                r   = dif9[7:0];
                f.n = 1'b1;
                f.h = dif5[4];
                f.c = dif9[8];
                if (t_alu_op'(i_operation) == OP_CP) begin
                    o_written = 1'b0;
                end
            end
            OP_AND: begin
                r = i_a & i_b; f.n = 1'b0; f.h = 1'b1; f.c = 1'b0;
            end
            OP_XOR: begin
                r = i_a ^ i_b; f.n = 1'b0; f.h = 1'b0; f.c = 1'b0;
            end
            OP_OR: begin
                r = i_a | i_b; f.n = 1'b0; f.h = 1'b0; f.c = 1'b0;
            end
            OP_INC: begin
                r = i_a + 8'd1; f.n = 1'b0; f.h = (i_a[3:0] == 4'hF);
            end
            OP_DEC: begin
                r = i_a - 8'd1; f.n = 1'b1; f.h = (i_a[3:0] == 4'h0);
            end
            OP_DAA: begin
                r   = daa_res;
                f.h = 1'b0;
                if (!i_flags.n && daa_hi) begin
                    f.c = 1'b1;
                end
            end
            OP_CPL: begin
                r = ~i_a; f.n = 1'b1; f.h = 1'b1; set_z = 1'b0;
            end
            OP_SCF: begin
                f.n = 1'b0; f.h = 1'b0; f.c = 1'b1; set_z = 1'b0;
            end
            OP_CCF: begin
                f.n = 1'b0; f.h = 1'b0; f.c = ~i_flags.c; set_z = 1'b0;
            end
            OP_RLC, OP_RLCA: begin
                r = {i_a[6:0], i_a[7]}; f.n = 1'b0; f.h = 1'b0; f.c = i_a[7];
            end
            OP_RRC, OP_RRCA: begin
                r = {i_a[0], i_a[7:1]}; f.n = 1'b0; f.h = 1'b0; f.c = i_a[0];
            end
            OP_RL, OP_RLA: begin
                r = {i_a[6:0], i_flags.c}; f.n = 1'b0; f.h = 1'b0; f.c = i_a[7];
            end
            OP_RR, OP_RRA: begin
                r = {i_flags.c, i_a[7:1]}; f.n = 1'b0; f.h = 1'b0; f.c = i_a[0];
            end
            OP_SLA: begin
                r = {i_a[6:0], 1'b0}; f.n = 1'b0; f.h = 1'b0; f.c = i_a[7];
            end
            OP_SRA: begin
                r = {i_a[7], i_a[7:1]}; f.n = 1'b0; f.h = 1'b0; f.c = i_a[0];
            end
            OP_SRL: begin
                r = {1'b0, i_a[7:1]}; f.n = 1'b0; f.h = 1'b0; f.c = i_a[0];
            end
            OP_SWAP: begin
                r = {i_a[3:0], i_a[7:4]}; f.n = 1'b0; f.h = 1'b0; f.c = 1'b0;
            end
            OP_BIT: begin
                o_written = 1'b0;
                set_z     = 1'b0;
                f.z       = ~|(i_b & bit_mask);
                f.n       = 1'b0;
                f.h       = 1'b1;
            end
            OP_RES: begin
                r = i_a & ~bit_mask; set_z = 1'b0;
            end
            OP_SET: begin
                r = i_a | bit_mask; set_z = 1'b0;
            end
            default: begin
                // Unassigned codes leave everything untouched.
                o_written = 1'b0;
                set_z     = 1'b0;
            end
        endcase
        if (set_z) begin
            f.z = (r == 8'd0);
        end
        // The accumulator rotates always clear Z.
        if ((t_alu_op'(i_operation) == OP_RLCA) || (t_alu_op'(i_operation) == OP_RRCA) ||
            (t_alu_op'(i_operation) == OP_RLA)  || (t_alu_op'(i_operation) == OP_RRA)) begin
            f.z = 1'b0;
        end
        o_result = r;
        o_flags  = f;
    end

endmodule : alu8f_core
`default_nettype wire

// ----- hdl/cpu_alu8_with_flags.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpu_alu8_with_flags
// Eight-bit CPU ALU with Z, N, H and C flags, registered in and out.
// ----------------------------------------------------------------------------
// An item is taken on every clock edge where start is high and busy is low,
// so one operation can enter in each cycle. Busy is high only while reset is
// held. An item's operands are captured in an input register, the ALU logic
// works on that register, and the result register captures its output and
// drives the outputs. o_result_valid is high for exactly one cycle per item
// and the result is gone after that cycle, so the receiver must take it then;
// there is no way to hold results off.
// ----------------------------------------------------------------------------
module cpu_alu8_with_flags
    import alu8f_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [OpWidth-1:0] i_operation,
    input  wire logic [7:0]         i_first_operand,
    input  wire logic [7:0]         i_second_operand,
    input  wire logic [2:0]         i_bit_index,
    input  wire logic               i_zero_in,
    input  wire logic               i_subtract_in,
    input  wire logic               i_half_in,
    input  wire logic               i_carry_in,
    output logic                    o_result_valid,
    output logic [7:0]              o_result,
    output logic                    o_result_written,
    output logic                    o_zero_flag,
    output logic                    o_subtract_flag,
    output logic                    o_half_flag,
    output logic                    o_carry_flag
);

    logic               r_in_valid;
    logic [OpWidth-1:0] r_op;
    logic [7:0]         r_a;
    logic [7:0]         r_b;
    logic [2:0]         r_bit_index;
    t_flags             r_flags_in;

    logic               r_out_valid;
    logic [7:0]         r_result;
    logic               r_written;
    t_flags             r_flags_out;

    logic               n_in_valid;
    logic [7:0]         n_result;
    logic               n_written;
    t_flags             n_flags_out;

    assign busy       = ~i_rst_n;
    assign n_in_valid = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_in_valid) begin
            r_op        <= i_operation;
            r_a         <= i_first_operand;
            r_b         <= i_second_operand;
            r_bit_index <= i_bit_index;
            r_flags_in  <= '{z: i_zero_in, n: i_subtract_in, h: i_half_in, c: i_carry_in};
        end
        if (r_in_valid) begin
            r_result    <= n_result;
            r_written   <= n_written;
            r_flags_out <= n_flags_out;
        end
    end

    alu8f_core u_core (
        .i_operation (r_op),
        .i_a         (r_a),
        .i_b         (r_b),
        .i_bit_index (r_bit_index),
        .i_flags     (r_flags_in),
        .o_result    (n_result),
        .o_written   (n_written),
        .o_flags     (n_flags_out)
    );

    assign o_result_valid   = r_out_valid;
    assign o_result         = r_result;
    assign o_result_written = r_written;
    assign o_zero_flag      = r_flags_out.z;
    assign o_subtract_flag  = r_flags_out.n;
    assign o_half_flag      = r_flags_out.h;
    assign o_carry_flag     = r_flags_out.c;

endmodule : cpu_alu8_with_flags
`default_nettype wire

// ----- hdl/alu8f_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alu8f_checker
// Port-level checks of item timing and of fixed results of a few operations.
// ----------------------------------------------------------------------------
module alu8f_checker
    import alu8f_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic [OpWidth-1:0] i_operation,
    input wire logic [7:0]         i_first_operand,
    input wire logic               o_result_valid,
    input wire logic [7:0]         o_result,
    input wire logic               o_result_written,
    input wire logic               o_carry_flag,
    input wire logic               o_half_flag
);

    logic accept;

    assign accept = start && !busy;

    // Every item taken yields a result strobe.
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 o_result_valid)
        else $error("item taken without a result two cycles later");

    // No result without a matching item taken earlier.
    a_no_spurious : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(accept, 2))
        else $error("result strobe without a matching item");

    // Set carry always leaves carry high.
    a_scf : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(accept, 2) && ($past(i_operation, 2) == OP_SCF)) |-> o_carry_flag)
        else $error("set carry did not set the carry flag");

    // Complement returns the inverted operand.
    a_cpl : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(accept, 2) && ($past(i_operation, 2) == OP_CPL))
        |-> (o_result == ~$past(i_first_operand, 2)))
        else $error("complement result wrong");

    // Bit test never writes back and always sets half carry.
    a_bit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(accept, 2) && ($past(i_operation, 2) == OP_BIT))
        |-> (!o_result_written && o_half_flag))
        else $error("bit test wrote back or left half carry clear");

endmodule : alu8f_checker

bind cpu_alu8_with_flags alu8f_checker u_alu8f_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_operation      (i_operation),
    .i_first_operand  (i_first_operand),
    .o_result_valid   (o_result_valid),
    .o_result         (o_result),
    .o_result_written (o_result_written),
    .o_carry_flag     (o_carry_flag),
    .o_half_flag      (o_half_flag)
);
`default_nettype wire
